// File: rtl/core/rgb2hsv_pkg.sv
// Package: shared constants for the RGB to HSV conversion pipeline.
`default_nettype none

package rgb2hsv_pkg;

  // Hue output width and scaling, in 1/64 degree units
  localparam int HUE_W = 15;
  localparam int HUE_SEXTANT = 3840;
  localparam int HUE_TURN = 23040;

  // Shift amounts that build 3840*n as (n << 12) - (n << 8)
  localparam int SEXTANT_HI_SHIFT = 12;
  localparam int SEXTANT_LO_SHIFT = 8;

  // Sextant offsets added to the channel difference, in units of delta
  localparam int OFFSET_RED_WRAP = 6;
  localparam int OFFSET_GREEN = 2;
  localparam int OFFSET_BLUE = 4;

endpackage

`default_nettype wire

// File: rtl/core/rgb_to_hsv_converter_core.sv
// RGB to HSV converter: max/min pipeline feeding two restoring dividers, one bit per stage.
// Stages: A, B and C, then S divider stages, then the output register, where
//   S = max(15, CHANNEL_BITS) is the number of divider stages. Throughput: one pixel
//   per cycle while m_tready does not stall; each divider stage resolves one quotient bit,
//   and every stage holds its own valid bit so a stall collapses bubbles and drops nothing.
// Reset: rst (synchronous, active high) clears all valid bits; data registers hold.
`default_nettype none

module rgb_to_hsv_converter_core #(
  parameter int CHANNEL_BITS = 8
) (
  input  wire  clk,
  input  wire  rst,
  // s_tdata fields, low bit up: red, green, blue, zero fill to whole bytes
  input  wire  [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
  input  wire  s_tvalid,
  output logic s_tready,
  // m_tdata fields, low bit up: hue (15), saturation, brightness, zero fill to whole bytes
  output logic [((rgb2hsv_pkg::HUE_W+2*CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
  output logic m_tvalid,
  input  wire  m_tready
);

  localparam int CB    = CHANNEL_BITS;
  localparam int HW    = rgb2hsv_pkg::HUE_W;
  localparam int S     = (HW > CB) ? HW : CB;
  localparam int L     = S + 4;
  localparam int OUT_W = ((HW + 2*CB + 7) / 8) * 8;
  localparam int NW    = CB + 3;
  localparam int DW    = CB + 4;
  localparam int NHW   = NW + rgb2hsv_pkg::SEXTANT_HI_SHIFT;
  localparam int NUMW  = S + CB;

  // Handshake chain: a stage loads when it is empty or its successor loads
  logic [L-1:0] v;
  logic [L:0]   rdy;

  assign rdy[L] = m_tready;

  genvar gi;
  generate
    for (gi = 0; gi < L; gi++) begin : g_valid
      assign rdy[gi] = !v[gi] || rdy[gi+1];
      if (gi == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (rst) begin
            v[gi] <= 1'b0;
          end else if (rdy[gi]) begin
            v[gi] <= s_tvalid;
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (rst) begin
            v[gi] <= 1'b0;
          end else if (rdy[gi]) begin
            v[gi] <= v[gi-1];
          end
        end
      end
    end
  endgenerate

  assign s_tready = rdy[0];
  assign m_tvalid = v[L-1];

  // Stage A: find the largest and smallest channel
  logic [CB-1:0] in_r, in_g, in_b;
  logic          in_rmax, in_gmax;
  logic [CB-1:0] in_mx, in_mn;
  logic [CB-1:0] a_r, a_g, a_b, a_mx, a_mn;
  logic          a_rmax, a_gmax;

  assign in_r = s_tdata[CB-1:0];
  assign in_g = s_tdata[2*CB-1:CB];
  assign in_b = s_tdata[3*CB-1:2*CB];

  always_comb begin
    in_rmax = (in_r >= in_g) && (in_r >= in_b);
    in_gmax = !in_rmax && (in_g >= in_b);
    if (in_rmax) begin
      in_mx = in_r;
    end else if (in_gmax) begin
      in_mx = in_g;
    end else begin
      in_mx = in_b;
    end
    if ((in_r <= in_g) && (in_r <= in_b)) begin
      in_mn = in_r;
    end else if (in_g <= in_b) begin
      in_mn = in_g;
    end else begin
      in_mn = in_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_r    <= in_r;
      a_g    <= in_g;
      a_b    <= in_b;
      a_mx   <= in_mx;
      a_mn   <= in_mn;
      a_rmax <= in_rmax;
      a_gmax <= in_gmax;
    end
  end

  // Stage B: delta and the sextant numerator n = diff + k*delta
  logic [CB-1:0] a_d;
  logic [DW-1:0] a_diff, a_koff, a_nfull;
  logic [CB-1:0] b_mx, b_d;
  logic [NW-1:0] b_n;
  logic          b_dz;

  always_comb begin
    a_d = a_mx - a_mn;
    if (a_rmax) begin
      a_diff = DW'(a_g) - DW'(a_b);
      a_koff = a_diff[DW-1] ? DW'(a_d) * DW'(rgb2hsv_pkg::OFFSET_RED_WRAP) : '0;
    end else if (a_gmax) begin
      a_diff = DW'(a_b) - DW'(a_r);
      a_koff = DW'(a_d) * DW'(rgb2hsv_pkg::OFFSET_GREEN);
    end else begin
      a_diff = DW'(a_r) - DW'(a_g);
      a_koff = DW'(a_d) * DW'(rgb2hsv_pkg::OFFSET_BLUE);
    end
    a_nfull = a_diff + a_koff;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b_mx <= a_mx;
      b_d  <= a_d;
      b_n  <= a_nfull[NW-1:0];
      b_dz <= (a_d == '0);
    end
  end

  // Stage C: scale to dividends and seed both dividers
  logic [CB-1:0] rem_h [S+1];
  logic [S-1:0]  lq_h  [S+1];
  logic [CB-1:0] rem_s [S+1];
  logic [S-1:0]  lq_s  [S+1];
  logic [CB-1:0] dv_h  [S+1];
  logic [CB-1:0] dv_s  [S+1];
  logic          dz    [S+1];

  logic [NHW-1:0]  b_hnum;
  logic [2*CB-1:0] b_snum;
  logic [NUMW-1:0] b_hdiv, b_sdiv;

  always_comb begin
    b_hnum = (NHW'(b_n) << rgb2hsv_pkg::SEXTANT_HI_SHIFT)
           - (NHW'(b_n) << rgb2hsv_pkg::SEXTANT_LO_SHIFT);
    b_snum = {b_d, {CB{1'b0}}} - (2*CB)'(b_d);
    b_hdiv = NUMW'(b_hnum);
    b_sdiv = NUMW'(b_snum);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      rem_h[0] <= b_hdiv[NUMW-1:S];
      lq_h[0]  <= b_hdiv[S-1:0];
      rem_s[0] <= b_sdiv[NUMW-1:S];
      lq_s[0]  <= b_sdiv[S-1:0];
      dv_h[0]  <= b_d;
      dv_s[0]  <= b_mx;
      dz[0]    <= b_dz;
    end
  end

  // Divider stages: shift in one dividend bit, subtract when it fits, record quotient bit
  generate
    for (gi = 0; gi < S; gi++) begin : g_div
      logic [CB:0] tmp_h, tmp_s, sub_h, sub_s;
      logic        ge_h, ge_s;

      always_comb begin
        tmp_h = {rem_h[gi], lq_h[gi][S-1]};
        tmp_s = {rem_s[gi], lq_s[gi][S-1]};
        sub_h = tmp_h - {1'b0, dv_h[gi]};
        sub_s = tmp_s - {1'b0, dv_s[gi]};
        ge_h  = (tmp_h >= {1'b0, dv_h[gi]});
        ge_s  = (tmp_s >= {1'b0, dv_s[gi]});
      end

      always_ff @(posedge clk) begin
        if (rdy[gi+3]) begin
          rem_h[gi+1] <= ge_h ? sub_h[CB-1:0] : tmp_h[CB-1:0];
          rem_s[gi+1] <= ge_s ? sub_s[CB-1:0] : tmp_s[CB-1:0];
          lq_h[gi+1]  <= {lq_h[gi][S-2:0], ge_h};
          lq_s[gi+1]  <= {lq_s[gi][S-2:0], ge_s};
          dv_h[gi+1]  <= dv_h[gi];
          dv_s[gi+1]  <= dv_s[gi];
          dz[gi+1]    <= dz[gi];
        end
      end
    end
  endgenerate

  // Output register: zero hue and saturation for a grey pixel
  logic [HW-1:0] o_hue;
  logic [CB-1:0] o_sat, o_bright;

  always_ff @(posedge clk) begin
    if (rdy[L-1]) begin
      o_hue    <= dz[S] ? '0 : lq_h[S][HW-1:0];
      o_sat    <= dz[S] ? '0 : lq_s[S][CB-1:0];
      o_bright <= dv_s[S];
    end
  end

  assign m_tdata = OUT_W'({o_bright, o_sat, o_hue});

  // Checks
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v[0])
    else $error("input transfer did not load the first stage");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(o_hue) < 32'(rgb2hsv_pkg::HUE_TURN)))
    else $error("hue at or above a full turn");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (o_bright == '0)) |-> ((o_sat == '0) && (o_hue == '0)))
    else $error("black pixel with nonzero hue or saturation");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (v[L-2] && !dz[S]) |-> ((rem_h[S] < dv_h[S]) && (rem_s[S] < dv_s[S])))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: sim/hsv_checker.sv
// Checker for the RGB to HSV core: predicts each pixel and compares the result stream.
`timescale 1ns / 1ps

module hsv_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire [23:0] s_tdata,
  input  wire        s_tvalid,
  input  wire        s_tready,
  input  wire [31:0] m_tdata,
  input  wire        m_tvalid,
  input  wire        m_tready,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [rgb2hsv_pkg::HUE_W-1:0] hue;
    logic [7:0]                    sat;
    logic [7:0]                    val;
  } hsv_t;

  hsv_t hsv_expected[$];

  // Exact integer HSV of one pixel: hue in 1/64 degree, saturation on 0..255
  function automatic hsv_t rgb_to_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned rr, gg, bb, mx, mn, d, num, q;
    hsv_t res;
    rr = 32'(r);
    gg = 32'(g);
    bb = 32'(b);
    mx = (rr > gg) ? rr : gg;
    mx = (mx > bb) ? mx : bb;
    mn = (rr < gg) ? rr : gg;
    mn = (mn < bb) ? mn : bb;
    d = mx - mn;
    res.hue = '0;
    res.sat = '0;
    res.val = mx[7:0];
    if (d != 0) begin
      // red wins ties, then green; red sextant wraps below zero degrees
      if (mx == rr) begin
        if (gg >= bb) num = rgb2hsv_pkg::HUE_SEXTANT * (gg - bb);
        else num = rgb2hsv_pkg::HUE_TURN * d - rgb2hsv_pkg::HUE_SEXTANT * (bb - gg);
      end else if (mx == gg) begin
        num = rgb2hsv_pkg::HUE_SEXTANT * (bb + 2 * d - rr);
      end else begin
        num = rgb2hsv_pkg::HUE_SEXTANT * (rr + 4 * d - gg);
      end
      q = num / d;
      res.hue = q[rgb2hsv_pkg::HUE_W-1:0];
      q = (255 * d) / mx;
      res.sat = q[7:0];
    end
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(string field, int got, int want);
    $display("%0t hsv_checker: %s got %0d expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // Queue a prediction on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    hsv_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        hsv_expected.push_back(rgb_to_hsv(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
      if (m_tvalid && m_tready) begin
        if (hsv_expected.size() == 0) begin
          report_mismatch("unexpected result, hue", int'(m_tdata[14:0]), -1);
        end else begin
          want = hsv_expected.pop_front();
          if (m_tdata[14:0] != want.hue)
            report_mismatch("hue", int'(m_tdata[14:0]), int'(want.hue));
          if (m_tdata[22:15] != want.sat)
            report_mismatch("saturation", int'(m_tdata[22:15]), int'(want.sat));
          if (m_tdata[30:23] != want.val)
            report_mismatch("brightness", int'(m_tdata[30:23]), int'(want.val));
          if (m_tdata[31] != 1'b0)
            report_mismatch("fill bit", int'(m_tdata[31]), 0);
        end
      end
    end
    outstanding <= hsv_expected.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top: drives pixels into the RGB to HSV core and gives the verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 330;

  logic        clk;
  logic        rst = 1'b1;
  logic [23:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  bit hold_taken = 1'b0;
  int quiet_cycles = 0;
  int mismatches;
  int outstanding;

  rgb_to_hsv_converter_core #(.CHANNEL_BITS(8)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  hsv_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tdata     (m_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Drive the receiver: one long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_taken <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pixel after random idle cycles and hold it until transferred
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, g, r};
    do @(posedge clk); while (!s_tready);
  endtask

  // Random pixel, weighted toward greys, tied maxima and small values
  task automatic send_random_pixel();
    logic [7:0] v, w, x;
    int kind;
    kind = int'($urandom_range(9));
    v = 8'($urandom_range(255));
    w = 8'($urandom_range(255));
    x = 8'($urandom_range(255));
    case (kind)
      0: send_pixel(v, v, v);
      1: begin
        w = 8'($urandom_range(v));
        case ($urandom_range(2))
          0: send_pixel(v, v, w);
          1: send_pixel(v, w, v);
          default: send_pixel(w, v, v);
        endcase
      end
      2: send_pixel(8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3)));
      3: send_pixel(8'hff, w & 8'h0f, x);
      default: send_pixel(v, w, x);
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: black, white, greys, primaries, ties, wrap of the red sextant
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h01, 8'h01, 8'h01);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h00);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'h01, 8'h00, 8'h01);
    send_pixel(8'hff, 8'h00, 8'h01);
    send_pixel(8'hff, 8'h10, 8'hf0);
    send_pixel(8'hc8, 8'h64, 8'h32);
    send_pixel(8'h32, 8'hc8, 8'h64);
    send_pixel(8'h64, 8'hc8, 8'h32);
    send_pixel(8'h32, 8'h64, 8'hc8);
    send_pixel(8'hc8, 8'h32, 8'hc7);
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h01);
    send_pixel(8'haa, 8'h55, 8'haa);
    send_pixel(8'h55, 8'haa, 8'h55);
    send_pixel(8'hfe, 8'hff, 8'h00);

    // Busy sender, slow receiver
    tx_idle_pct = 32;
    rx_idle_pct = 59;
    repeat (PHASE_ITEMS) send_random_pixel();

    // Slow sender, busy receiver
    tx_idle_pct = 59;
    rx_idle_pct = 32;
    repeat (PHASE_ITEMS) send_random_pixel();

    // Full rate, opened by a long receiver hold-off to back up the pipeline
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= 1'b1;
    repeat (PHASE_ITEMS) send_random_pixel();
    s_tvalid <= 1'b0;

    // Drain the pipeline, then let it settle
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
